/* hw/rtl/dfa_row_merge_compressor_macros.svh */
// Assertion macros shared by the row merge compressor RTL.
// Depends on nothing; included by the top level.
`ifndef DFA_ROW_MERGE_COMPRESSOR_MACROS_SVH
`define DFA_ROW_MERGE_COMPRESSOR_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define DRM_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent in one cycle implies the consequent in the next.
`define DRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/drm_pkg.sv */
// Package of the row merge compressor: sizes, entry type and controller states.
// Depends on nothing.
`default_nettype none
package drm_pkg;
    localparam int MAX_COLS    = 256;
    localparam int MAX_ROWS    = 512;
    localparam int VALUE_WIDTH = 16;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic        dc;
        logic [15:0] val;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FILL_RD,
        S_FILL_WR,
        S_NOMATCH,
        S_APP_RD,
        S_APP_WR,
        S_RD_WAIT,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

/* hw/rtl/dfa_row_merge_compressor.sv */
// Top level of the row merge compressor: controller, counters, output register.
// Depends on drm_pkg, drm_store and dfa_row_merge_compressor_macros.svh.
//
// Usage: items enter on the input channel (i_in_valid / o_in_ready) with a
// mode. A load item writes one element of the pending row; the element that
// completes a row starts a search of the stored rows. Each stored row is
// compared column by column (a memory read state, then a check state),
// stopping at the first mismatch. A matching row then has its wildcard
// entries filled column by column (read, then write); a new row is written
// over all MAX_COLS columns, also with a read and a write per column. A
// read item gives one result; a load that does not complete a row or a
// clear gives no result. The search, the fill and the append all run
// column-serially through the single read port of the merged table.
// Results leave through an output register (o_out_valid / i_out_ready); a
// stalled receiver holds the result and the controller waits in its done
// state once a second result is ready. The configuration channel writes
// row_length at any time and is always ready. After synchronous reset the
// table is empty, the row position is zero and row_length is 256; no
// clearing pass is needed.
`default_nettype none
`include "dfa_row_merge_compressor_macros.svh"
module dfa_row_merge_compressor #(
    parameter int MAX_COLS    = drm_pkg::MAX_COLS,
    parameter int MAX_ROWS    = drm_pkg::MAX_ROWS,
    parameter int VALUE_WIDTH = drm_pkg::VALUE_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_value,
    input  wire logic        i_dont_care,
    input  wire logic [8:0]  i_read_row,
    input  wire logic [7:0]  i_read_col,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [8:0]       o_row_group,
    output logic             o_new_row,
    output logic             o_overflow,
    output logic [15:0]      o_read_value,
    output logic             o_read_dont_care,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [8:0]  i_cfg_data
);
    localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int KW = $clog2(MAX_ROWS + 1);
    localparam logic [15:0] VMASK =
        (VALUE_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << VALUE_WIDTH) - 32'd1);

    drm_pkg::t_state r_state, n_state;
    logic [8:0]    r_row_length;
    logic [NW-1:0] r_pos, n_pos;
    logic [KW-1:0] r_count, n_count;
    logic [RW-1:0] r_r, n_r;
    logic [NW-1:0] r_c, n_c;
    logic [8:0]    r_res_grp, n_res_grp;
    logic          r_res_new, n_res_new, r_res_ovf, n_res_ovf, r_res_rdc, n_res_rdc;
    logic [15:0]   r_res_val, n_res_val;
    logic          r_out_valid;

    logic [NW-1:0]   eff_len;
    logic [10:0]     len_ext;
    logic            accept, out_free;
    logic [AW-1:0]   tab_raddr, tab_waddr;
    logic            tab_we, pend_we;
    drm_pkg::t_entry tab_wdata, pend_wdata, tab_q, pend_q;
    logic            agree;
    logic            last_col, last_row, read_miss;

    always_comb begin
        len_ext = {2'b00, r_row_length};
        if (len_ext == 11'd0) begin
            len_ext = 11'd1;
        end
        if (len_ext > 11'(MAX_COLS)) begin
            len_ext = 11'(MAX_COLS);
        end
        eff_len = NW'(len_ext);
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == drm_pkg::S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign last_col    = (11'(r_c) + 11'd1) >= 11'(eff_len);
    assign last_row    = (13'(r_r) + 13'd1) >= 13'(r_count);
    assign read_miss   = (13'(i_read_row) >= 13'(r_count)) ||
                         (13'(i_read_row) >= 13'(MAX_ROWS)) ||
                         (11'(i_read_col) >= 11'(MAX_COLS));

    drm_store #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_store (
        .i_clk       (i_clk),
        .i_tab_raddr (tab_raddr),
        .i_tab_we    (tab_we),
        .i_tab_waddr (tab_waddr),
        .i_tab_wdata (tab_wdata),
        .i_pend_raddr(r_c[CW-1:0]),
        .i_pend_we   (pend_we),
        .i_pend_waddr(r_pos[CW-1:0]),
        .i_pend_wdata(pend_wdata),
        .o_tab_q     (tab_q),
        .o_pend_q    (pend_q),
        .o_agree     (agree)
    );

    // Next state and datapath.
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_count   = r_count;
        n_r       = r_r;
        n_c       = r_c;
        n_res_grp = r_res_grp;
        n_res_new = r_res_new;
        n_res_ovf = r_res_ovf;
        n_res_val = r_res_val;
        n_res_rdc = r_res_rdc;
        unique case (r_state)
            drm_pkg::S_IDLE: begin
                if (accept) begin
                    n_res_grp = '0;
                    n_res_new = 1'b0;
                    n_res_ovf = 1'b0;
                    n_res_val = '0;
                    n_res_rdc = 1'b0;
                    unique case (i_mode)
                        drm_pkg::MODE_LOAD: begin
                            if ((11'(r_pos) + 11'd1) < 11'(eff_len)) begin
                                n_pos = r_pos + NW'(1);
                            end else begin
                                n_pos = '0;
                                n_r   = '0;
                                n_c   = '0;
                                n_state = (r_count == '0) ? drm_pkg::S_NOMATCH
                                                          : drm_pkg::S_SCAN_RD;
                            end
                        end
                        drm_pkg::MODE_READ: begin
                            if (read_miss) begin
                                n_res_rdc = 1'b1;
                                n_state   = drm_pkg::S_DONE;
                            end else begin
                                n_state = drm_pkg::S_RD_WAIT;
                            end
                        end
                        drm_pkg::MODE_CLEAR: begin
                            n_count = '0;
                            n_pos   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            drm_pkg::S_SCAN_RD: n_state = drm_pkg::S_SCAN_CHK;
            drm_pkg::S_SCAN_CHK: begin
                if (!agree) begin
                    n_c = '0;
                    if (last_row) begin
                        n_state = drm_pkg::S_NOMATCH;
                    end else begin
                        n_r     = r_r + RW'(1);
                        n_state = drm_pkg::S_SCAN_RD;
                    end
                end else if (last_col) begin
                    n_c     = '0;
                    n_state = drm_pkg::S_FILL_RD;
                end else begin
                    n_c     = r_c + NW'(1);
                    n_state = drm_pkg::S_SCAN_RD;
                end
            end
            drm_pkg::S_FILL_RD: n_state = drm_pkg::S_FILL_WR;
            drm_pkg::S_FILL_WR: begin
                if (last_col) begin
                    n_res_grp = 9'(r_r);
                    n_state   = drm_pkg::S_DONE;
                end else begin
                    n_c     = r_c + NW'(1);
                    n_state = drm_pkg::S_FILL_RD;
                end
            end
            drm_pkg::S_NOMATCH: begin
                if (r_count >= KW'(MAX_ROWS)) begin
                    n_res_ovf = 1'b1;
                    n_state   = drm_pkg::S_DONE;
                end else begin
                    n_r     = RW'(r_count);
                    n_c     = '0;
                    n_state = drm_pkg::S_APP_RD;
                end
            end
            drm_pkg::S_APP_RD: n_state = drm_pkg::S_APP_WR;
            drm_pkg::S_APP_WR: begin
                if ((11'(r_c) + 11'd1) >= 11'(MAX_COLS)) begin
                    n_count   = r_count + KW'(1);
                    n_res_grp = 9'(r_r);
                    n_res_new = 1'b1;
                    n_state   = drm_pkg::S_DONE;
                end else begin
                    n_c     = r_c + NW'(1);
                    n_state = drm_pkg::S_APP_RD;
                end
            end
            drm_pkg::S_RD_WAIT: begin
                n_res_val = tab_q.dc ? 16'd0 : tab_q.val;
                n_res_rdc = tab_q.dc;
                n_state   = drm_pkg::S_DONE;
            end
            drm_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = drm_pkg::S_IDLE;
                end
            end
            default: n_state = drm_pkg::S_IDLE;
        endcase
    end

    // Memory controls.
    always_comb begin
        tab_raddr  = AW'(r_r) * AW'(MAX_COLS) + AW'(r_c[CW-1:0]);
        tab_waddr  = tab_raddr;
        tab_we     = 1'b0;
        tab_wdata  = pend_q;
        pend_we    = 1'b0;
        pend_wdata.dc  = i_dont_care;
        pend_wdata.val = i_dont_care ? 16'd0 : (i_value & VMASK);
        unique case (r_state)
            drm_pkg::S_IDLE: begin
                tab_raddr = AW'(RW'(i_read_row)) * AW'(MAX_COLS) + AW'(CW'(i_read_col));
                pend_we   = accept && (i_mode == drm_pkg::MODE_LOAD);
            end
            drm_pkg::S_FILL_WR: begin
                tab_we = tab_q.dc;
            end
            drm_pkg::S_APP_WR: begin
                tab_we = 1'b1;
                if ((11'(r_c) >= 11'(eff_len))) begin
                    tab_wdata.dc  = 1'b1;
                    tab_wdata.val = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= drm_pkg::S_IDLE;
            r_row_length <= 9'd256;
            r_pos        <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_row_length <= i_cfg_data;
            end
            if (r_state == drm_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r       <= n_r;
        r_c       <= n_c;
        r_res_grp <= n_res_grp;
        r_res_new <= n_res_new;
        r_res_ovf <= n_res_ovf;
        r_res_val <= n_res_val;
        r_res_rdc <= n_res_rdc;
        if (r_state == drm_pkg::S_DONE && out_free) begin
            o_row_group      <= r_res_grp;
            o_new_row        <= r_res_new;
            o_overflow       <= r_res_ovf;
            o_read_value     <= r_res_val;
            o_read_dont_care <= r_res_rdc;
        end
    end

    assign o_out_valid = r_out_valid;

    `DRM_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= KW'(MAX_ROWS))
    `DRM_ASSERT_ALWAYS(a_pos_bound, i_clk, i_rst_n, 11'(r_pos) < 11'(MAX_COLS))
    `DRM_ASSERT_NEXT(a_done_shows, i_clk, i_rst_n,
        (r_state == drm_pkg::S_DONE) && out_free, o_out_valid && (r_state == drm_pkg::S_IDLE))
endmodule
`default_nettype wire

/* hw/rtl/drm_store.sv */
// Merged table and pending row memories with registered reads and the
// per-column agreement check. Depends on drm_pkg.
`default_nettype none
module drm_store #(
    parameter int MAX_ROWS = drm_pkg::MAX_ROWS,
    parameter int MAX_COLS = drm_pkg::MAX_COLS,
    localparam int AW = $clog2(MAX_ROWS * MAX_COLS),
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  wire logic            i_clk,
    input  wire logic [AW-1:0]   i_tab_raddr,
    input  wire logic            i_tab_we,
    input  wire logic [AW-1:0]   i_tab_waddr,
    input  wire drm_pkg::t_entry i_tab_wdata,
    input  wire logic [CW-1:0]   i_pend_raddr,
    input  wire logic            i_pend_we,
    input  wire logic [CW-1:0]   i_pend_waddr,
    input  wire drm_pkg::t_entry i_pend_wdata,
    output drm_pkg::t_entry      o_tab_q,
    output drm_pkg::t_entry      o_pend_q,
    output logic                 o_agree
);
    drm_pkg::t_entry r_tab_mem [MAX_ROWS*MAX_COLS];
    drm_pkg::t_entry r_pend_mem [MAX_COLS];

    always_ff @(posedge i_clk) begin
        if (i_tab_we) begin
            r_tab_mem[i_tab_waddr] <= i_tab_wdata;
        end
        o_tab_q <= r_tab_mem[i_tab_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_pend_we) begin
            r_pend_mem[i_pend_waddr] <= i_pend_wdata;
        end
        o_pend_q <= r_pend_mem[i_pend_raddr];
    end

    // Two entries agree when either is a wildcard or the values match.
    assign o_agree = o_tab_q.dc || o_pend_q.dc || (o_tab_q.val == o_pend_q.val);
endmodule
`default_nettype wire

/* dv/tb.sv */
// Testbench of the row merge compressor: directed and random transactions checked
// against an in-bench predictor of the merged table. Depends on drm_pkg and the RTL.
`timescale 1ns / 100ps
module tb;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [8:0]  grp;
        logic        nw;
        logic        ov;
        logic [15:0] rv;
        logic        rdc;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_mode = drm_pkg::MODE_LOAD;
    logic [15:0] i_value = '0;
    logic        i_dont_care = 1'b0;
    logic [8:0]  i_read_row = '0;
    logic [7:0]  i_read_col = '0;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [8:0]  o_row_group;
    logic        o_new_row;
    logic        o_overflow;
    logic [15:0] o_read_value;
    logic        o_read_dont_care;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data = '0;

    dfa_row_merge_compressor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_mode(i_mode), .i_value(i_value), .i_dont_care(i_dont_care),
        .i_read_row(i_read_row), .i_read_col(i_read_col),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_row_group(o_row_group), .o_new_row(o_new_row), .o_overflow(o_overflow),
        .o_read_value(o_read_value), .o_read_dont_care(o_read_dont_care),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    drm_pkg::t_entry merged_rows [0:drm_pkg::MAX_ROWS-1][0:drm_pkg::MAX_COLS-1];
    drm_pkg::t_entry row_buffer [0:drm_pkg::MAX_COLS-1];
    int          load_pos = 0;
    int          row_count = 0;
    logic [8:0]  row_len_reg = 9'd256;
    t_result     pending_results [$];

    int          errors = 0;
    int          cycles = 0;
    bit          no_idle = 0;
    int          hold_cycles = 0;
    logic        rdy_r = 1'b0;
    int          rdy_stall = 0;
    int          rdy_draw;

    assign i_out_ready = rdy_r && (hold_cycles == 0);

    function automatic int row_width();
        if (row_len_reg < 1) return 1;
        if (row_len_reg > drm_pkg::MAX_COLS) return drm_pkg::MAX_COLS;
        return row_len_reg;
    endfunction

    function automatic t_result make_result(int grp, bit nw, bit ov, int rv, bit rdc);
        t_result r;
        r.grp = grp[8:0];
        r.nw  = nw;
        r.ov  = ov;
        r.rv  = rv[15:0];
        r.rdc = rdc;
        return r;
    endfunction

    function automatic void queue_result(t_result r);
        pending_results = {pending_results, r};
    endfunction

    function automatic void predict_merge(logic [1:0] mode, logic [15:0] value, logic dc,
                                          logic [8:0] rrow, logic [7:0] rcol);
        int  n;
        bit  agree;
        if (mode == drm_pkg::MODE_LOAD) begin
            n = row_width();
            row_buffer[load_pos].dc  = dc;
            row_buffer[load_pos].val = dc ? 16'd0 : value;
            if (load_pos + 1 < n) begin
                load_pos++;
                return;
            end
            load_pos = 0;
            for (int r = 0; r < row_count; r++) begin
                agree = 1;
                for (int c = 0; c < n; c++)
                    if (!merged_rows[r][c].dc && !row_buffer[c].dc &&
                        merged_rows[r][c].val != row_buffer[c].val)
                        agree = 0;
                if (agree) begin
                    for (int c = 0; c < n; c++)
                        if (merged_rows[r][c].dc) merged_rows[r][c] = row_buffer[c];
                    queue_result(make_result(r, 0, 0, 0, 0));
                    return;
                end
            end
            if (row_count >= drm_pkg::MAX_ROWS) begin
                queue_result(make_result(0, 0, 1, 0, 0));
                return;
            end
            for (int c = 0; c < drm_pkg::MAX_COLS; c++) begin
                if (c < n) begin
                    merged_rows[row_count][c] = row_buffer[c];
                end else begin
                    merged_rows[row_count][c].dc  = 1'b1;
                    merged_rows[row_count][c].val = 16'd0;
                end
            end
            queue_result(make_result(row_count, 1, 0, 0, 0));
            row_count++;
        end else if (mode == drm_pkg::MODE_READ) begin
            if (rrow >= row_count)
                queue_result(make_result(0, 0, 0, 0, 1));
            else
                queue_result(make_result(0, 0, 0,
                    merged_rows[rrow][rcol].val, merged_rows[rrow][rcol].dc));
        end else if (mode == drm_pkg::MODE_CLEAR) begin
            row_count = 0;
            load_pos  = 0;
        end
    endfunction

    task automatic report(string field, int got, int exp);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", field, got, exp, cycles);
        errors++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", o_row_group, 0);
            end else begin
                if (o_row_group !== pending_results[0].grp)
                    report("row_group", o_row_group, pending_results[0].grp);
                if (o_new_row !== pending_results[0].nw)
                    report("new_row", o_new_row, pending_results[0].nw);
                if (o_overflow !== pending_results[0].ov)
                    report("overflow", o_overflow, pending_results[0].ov);
                if (o_read_value !== pending_results[0].rv)
                    report("read_value", o_read_value, pending_results[0].rv);
                if (o_read_dont_care !== pending_results[0].rdc)
                    report("read_dont_care", o_read_dont_care, pending_results[0].rdc);
                void'(pending_results.pop_front());
            end
        end
    end

    // Receiver: a random stall, possibly none, after each accepted result.
    always @(posedge i_clk) begin
        if (rdy_stall > 0) begin
            rdy_stall <= rdy_stall - 1;
        end else if (!rdy_r) begin
            rdy_r <= 1'b1;
        end else if (i_out_ready && o_out_valid) begin
            rdy_draw = no_idle ? 0 : $urandom_range(0, 16);
            if (rdy_draw > 0) begin
                rdy_r     <= 1'b0;
                rdy_stall <= rdy_draw - 1;
            end
        end
    end

    // Long receiver hold-off, counted down here once a test sets it.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sends one transaction; called at a rising edge, returns at the accepting edge.
    task automatic send_item(logic [1:0] mode, logic [15:0] value, logic dc,
                             logic [8:0] rrow, logic [7:0] rcol);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_value     <= value;
        i_dont_care <= dc;
        i_read_row  <= rrow;
        i_read_col  <= rcol;
        do @(posedge i_clk); while (!o_in_ready);
        predict_merge(mode, value, dc, rrow, rcol);
    endtask

    task automatic load(logic [15:0] value, logic dc);
        send_item(drm_pkg::MODE_LOAD, value, dc, 9'($urandom), 8'($urandom));
    endtask

    task automatic read_entry(int rrow, int rcol);
        send_item(drm_pkg::MODE_READ, 16'($urandom), 1'($urandom), rrow[8:0], rcol[7:0]);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Only while idle: all results are in and any last load has settled.
    task automatic write_row_length(logic [8:0] len);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        row_len_reg = len;
    endtask

    task automatic test_directed();
        write_row_length(9'd2);
        load(16'h0000, 1'b0);
        load(16'hFFFF, 1'b1);
        load(16'h0000, 1'b1);
        load(16'h1234, 1'b0);
        load(16'hFFFF, 1'b0);
        load(16'hABCD, 1'b1);
        read_entry(0, 0);
        read_entry(0, 1);
        read_entry(0, 2);
        read_entry(1, 255);
        read_entry(2, 0);
        read_entry(511, 255);
        send_item(MODE_UNUSED, 16'hFFFF, 1'b1, 9'h1FF, 8'hFF);
        load(16'h5555, 1'b0);
        send_item(drm_pkg::MODE_CLEAR, 16'h0, 1'b0, 9'h0, 8'h0);
        read_entry(0, 0);
        write_row_length(9'd3);
        load(16'h0007, 1'b0);
        load(16'h0008, 1'b0);
        // A partial row is finished early when the length shrinks.
        write_row_length(9'd0);
        load(16'h0009, 1'b0);
        read_entry(0, 1);
        write_row_length(9'd511);
        for (int c = 0; c < drm_pkg::MAX_COLS; c++)
            load(16'($urandom), ($urandom_range(0, 3) == 0));
        read_entry(1, 255);
        write_row_length(9'd256);
    endtask

    task automatic test_random(int items);
        int sel;
        int len;
        for (int ph = 0; ph < 7; ph++) begin
            len = (ph < 4) ? ph + 1 : $urandom_range(1, 8);
            write_row_length(len[8:0]);
            send_item(drm_pkg::MODE_CLEAR, 16'($urandom), 1'($urandom),
                      9'($urandom), 8'($urandom));
            no_idle = (ph == 3);
            for (int i = 0; i < items / 7; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 65)
                    load(($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)),
                         ($urandom_range(0, 3) == 0));
                else if (sel < 90)
                    read_entry(($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
                               : $urandom_range(0, row_count + 1), $urandom_range(0, 255));
                else if (sel < 93)
                    send_item(drm_pkg::MODE_CLEAR, 16'($urandom), 1'($urandom),
                              9'($urandom), 8'($urandom));
                else if (sel < 96)
                    send_item(MODE_UNUSED, 16'($urandom), 1'($urandom),
                              9'($urandom), 8'($urandom));
                else
                    // Sender pauses until everything sent has come back.
                    drain();
            end
            no_idle = 0;
        end
    endtask

    task automatic test_backpressure();
        write_row_length(9'd1);
        @(posedge i_clk);
        hold_cycles <= 400;
        for (int i = 0; i < 30; i++) begin
            if (i % 3 == 0) load(16'($urandom_range(0, 7)), 1'b0);
            else read_entry($urandom_range(0, 4), 0);
        end
    endtask

    task automatic test_overflow();
        write_row_length(9'd1);
        send_item(drm_pkg::MODE_CLEAR, 16'h0, 1'b0, 9'h0, 8'h0);
        no_idle = 1;
        for (int i = 0; i < drm_pkg::MAX_ROWS + 2; i++) load(i[15:0], 1'b0);
        load(16'd5, 1'b0);
        read_entry(511, 0);
        read_entry(511, 1);
        no_idle = 0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(140);
        test_backpressure();
        test_overflow();
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* dfa_row_merge_compressor.f */
+incdir+hw/rtl
hw/rtl/drm_pkg.sv
hw/rtl/drm_store.sv
hw/rtl/dfa_row_merge_compressor.sv
dv/tb.sv
